@@ hdl/bcc_pkg.sv @@
// Shared constants, codes and widths for the battery CC/CV test controller.
`default_nettype none

package bcc_pkg;

   // Default number of cells under test.
   localparam int CELLS_DEFAULT = 2;

   // Request type codes.
   localparam logic [1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_COMMAND = 2'd2;
   localparam logic [1:0] REQ_SET     = 2'd3;

   // Test control codes; the unused code acts as keep.
   localparam logic [1:0] CTL_KEEP  = 2'd0;
   localparam logic [1:0] CTL_STOP  = 2'd1;
   localparam logic [1:0] CTL_START = 2'd2;

   // Result kind codes.
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_DUTY   = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Configuration register indexes and reset values.
   localparam int         CSR_IDX_W          = 1;
   localparam int         CSR_DATA_W         = 16;
   localparam logic [0:0] CSR_FEEDBACK_GAIN  = 1'b0;
   localparam logic [0:0] CSR_PWM_FULL_SCALE = 1'b1;
   localparam logic [7:0]  GAIN_RESET        = 8'd1;
   localparam logic [15:0] PWM_FS_RESET      = 16'd255;

   // Cutoff timer value at which a constant-voltage phase ends.
   localparam logic [7:0] TIMER_LIMIT = 8'd255;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 9;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

endpackage

`default_nettype wire

@@ hdl/bcc_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none

module bcc_mul (
   input  wire logic                                clock,
   input  wire logic signed [bcc_pkg::MUL_A_W-1:0]  op_a,
   input  wire logic signed [bcc_pkg::MUL_B_W-1:0]  op_b,
   output logic signed      [bcc_pkg::PROD_W-1:0]   prod_ff
);
   import bcc_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ hdl/battery_cc_cv_test_controller.sv @@
// Top level of the multi-cell CC/CV battery test controller.
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_stall  type, cell, sample, control, limits
//   rsp_      out   rsp_valid / rsp_stall  kind, cell, duty, flag, energy, capacity, last
//   csr_      in    csr_wr_en              csr_index, csr_wdata
//
// All multiplication runs through one registered multiplier under a small sequencer.
// A stopped cell's sample goes straight to emit, a running cell's via multiply, limit,
// cutoff (skipped on a clamp) and emit; a tick runs multiply, accumulate, emit per cell.
// Reset is synchronous and clears all control and per-cell state at once.
// The result register lets the next beat in while a finished result waits; the
// sequencer only holds in its emit step while rsp_stall keeps that register full.
`default_nettype none

module battery_cc_cv_test_controller #(
   parameter int CELLS = bcc_pkg::CELLS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_type,
   input  wire logic [2:0]                         req_cell_req,
   input  wire logic signed [15:0]                 req_sample,
   input  wire logic [1:0]                         req_control,
   input  wire logic signed [15:0]                 req_bound_voltage,
   input  wire logic [6:0]                         req_max_current,
   input  wire logic [7:0]                         req_cutoff_ratio,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_kind,
   output logic [2:0]                              rsp_cell_res,
   output logic [15:0]                             rsp_duty,
   output logic                                    rsp_in_progress,
   output logic signed [63:0]                      rsp_energy,
   output logic [31:0]                             rsp_capacity,
   output logic                                    rsp_last,
   // configuration port
   input  wire logic                               csr_wr_en,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bcc_pkg::*;

   localparam int         CIW        = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [3:0] CELL_LIMIT = 4'(CELLS);
   localparam logic [CIW-1:0] LAST_CELL = CIW'(CELLS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SMP_MUL,
      S_SMP_LIM,
      S_SMP_CUT,
      S_TCK_MUL,
      S_TCK_ACC,
      S_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [7:0]  gain_ff;
   logic [15:0] pwm_fs_ff;

   // per-cell state
   logic [CIW-1:0]    sel_ff;
   logic [CIW-1:0]    tick_idx_ff;
   logic signed [15:0] target_ff   [CELLS];
   logic [6:0]        limit_ff    [CELLS];
   logic [7:0]        factor_ff   [CELLS];
   logic              running_ff  [CELLS];
   logic [7:0]        timer_ff    [CELLS];
   logic signed [7:0] drive_ff    [CELLS];
   logic signed [15:0] voltage_ff [CELLS];
   logic [63:0]       energy_ff   [CELLS];
   logic [31:0]       capacity_ff [CELLS];

   // item being worked on
   logic signed [15:0] sample_ff;
   logic signed [7:0]  drive_try_ff;

   // result waiting for the output register
   logic [1:0]  pend_kind_ff;
   logic [2:0]  pend_cell_ff;
   logic [15:0] pend_duty_ff;
   logic        pend_prog_ff;
   logic [63:0] pend_energy_ff;
   logic [31:0] pend_cap_ff;
   logic        pend_last_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [2:0]  rsp_cell_ff;
   logic [15:0] rsp_duty_ff;
   logic        rsp_prog_ff;
   logic [63:0] rsp_energy_ff;
   logic [31:0] rsp_cap_ff;
   logic        rsp_last_ff;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;

   bcc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   // combinational helpers
   logic           req_accept;
   logic           out_free;
   logic           rsp_load;
   logic [CIW-1:0] sel_in;
   logic [CIW-1:0] cmd_idx;
   logic           cmd_in_range;
   logic           run_in;
   logic signed [15:0] cv;
   logic [16:0]    cv_mag;
   logic [7:0]     lim8;
   logic           clamp;
   logic [7:0]     drive_clamp;
   logic [15:0]    cut_mag;
   logic signed [7:0] tick_drive;
   logic [7:0]     tick_drive_abs;

   assign req_accept   = req_valid && !req_stall;
   assign req_stall    = reset || (state_ff != S_IDLE);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_load     = (state_ff == S_EMIT) && out_free;
   assign sel_in       = (sel_ff == LAST_CELL) ? '0 : sel_ff + CIW'(1);
   assign cmd_idx      = req_cell_req[CIW-1:0];
   assign cmd_in_range = ({1'b0, req_cell_req} < CELL_LIMIT);

   always_comb begin
      case (req_control)
         CTL_STOP:  run_in = 1'b0;
         CTL_START: run_in = 1'b1;
         default:   run_in = running_ff[cmd_idx];
      endcase
   end

   // The low 16 bits of the gain product are the wrapped constant-voltage drive.
   assign cv          = prod_ff[15:0];
   assign cv_mag      = cv[15] ? (17'd0 - {1'b1, cv}) : {1'b0, cv};
   assign lim8        = {1'b0, limit_ff[sel_ff]};
   assign clamp       = (cv_mag > {10'd0, limit_ff[sel_ff]});
   assign drive_clamp = cv[15] ? (8'd0 - lim8) : lim8;
   assign cut_mag     = prod_ff[PROD_W-1] ? 16'(-prod_ff) : prod_ff[15:0];

   assign tick_drive     = drive_ff[tick_idx_ff];
   assign tick_drive_abs = tick_drive[7] ? (8'd0 - tick_drive) : tick_drive;

   always_comb begin
      case (state_ff)
         S_SMP_MUL: begin
            mul_a = {target_ff[sel_ff][15], target_ff[sel_ff]} - {sample_ff[15], sample_ff};
            mul_b = {1'b0, gain_ff};
         end
         S_SMP_LIM: begin
            mul_a = {{9{cv[7]}}, cv[7:0]};
            mul_b = {1'b0, factor_ff[sel_ff]};
         end
         S_TCK_MUL: begin
            mul_a = {voltage_ff[tick_idx_ff][15], voltage_ff[tick_idx_ff]};
            mul_b = {tick_drive[7], tick_drive};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= GAIN_RESET;
         pwm_fs_ff    <= PWM_FS_RESET;
         sel_ff       <= '0;
         tick_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CELLS; i++) begin
            target_ff[i]   <= '0;
            limit_ff[i]    <= '0;
            factor_ff[i]   <= '0;
            running_ff[i]  <= 1'b0;
            timer_ff[i]    <= '0;
            drive_ff[i]    <= '0;
            voltage_ff[i]  <= '0;
            energy_ff[i]   <= '0;
            capacity_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FEEDBACK_GAIN:  gain_ff   <= csr_wdata[7:0];
               CSR_PWM_FULL_SCALE: pwm_fs_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  pend_duty_ff <= '0;
                  pend_last_ff <= 1'b1;
                  case (req_type)
                     REQ_SAMPLE: begin
                        pend_kind_ff       <= KIND_SAMPLE;
                        pend_prog_ff       <= 1'b0;
                        pend_energy_ff     <= '0;
                        pend_cap_ff        <= '0;
                        sample_ff          <= req_sample;
                        voltage_ff[sel_ff] <= req_sample;
                        if (running_ff[sel_ff]) begin
                           state_ff <= S_SMP_MUL;
                        end else begin
                           drive_ff[sel_ff] <= '0;
                           sel_ff           <= sel_in;
                           pend_cell_ff     <= 3'(sel_in);
                           state_ff         <= S_EMIT;
                        end
                     end
                     REQ_TICK: begin
                        tick_idx_ff <= '0;
                        state_ff    <= S_TCK_MUL;
                     end
                     REQ_COMMAND: begin
                        pend_kind_ff   <= KIND_REPORT;
                        pend_cell_ff   <= req_cell_req;
                        pend_prog_ff   <= cmd_in_range && run_in;
                        pend_energy_ff <= cmd_in_range ? energy_ff[cmd_idx] : '0;
                        pend_cap_ff    <= cmd_in_range ? capacity_ff[cmd_idx] : '0;
                        if (cmd_in_range) begin
                           running_ff[cmd_idx]  <= run_in;
                           energy_ff[cmd_idx]   <= '0;
                           capacity_ff[cmd_idx] <= '0;
                        end
                        state_ff <= S_EMIT;
                     end
                     default: begin
                        if (cmd_in_range) begin
                           target_ff[cmd_idx] <= req_bound_voltage;
                           limit_ff[cmd_idx]  <= req_max_current;
                           factor_ff[cmd_idx] <= req_cutoff_ratio;
                        end
                     end
                  endcase
               end
            end
            S_SMP_MUL: begin
               state_ff <= S_SMP_LIM;
            end
            S_SMP_LIM: begin
               if (clamp) begin
                  // Constant-current mode: hold the drive at the limit.
                  drive_ff[sel_ff] <= drive_clamp;
                  timer_ff[sel_ff] <= '0;
                  sel_ff           <= sel_in;
                  pend_cell_ff     <= 3'(sel_in);
                  state_ff         <= S_EMIT;
               end else begin
                  drive_try_ff <= cv[7:0];
                  state_ff     <= S_SMP_CUT;
               end
            end
            S_SMP_CUT: begin
               if (cut_mag < {9'd0, limit_ff[sel_ff]}) begin
                  if (timer_ff[sel_ff] == TIMER_LIMIT) begin
                     running_ff[sel_ff] <= 1'b0;
                     timer_ff[sel_ff]   <= '0;
                     drive_ff[sel_ff]   <= '0;
                  end else begin
                     timer_ff[sel_ff] <= timer_ff[sel_ff] + 8'd1;
                     drive_ff[sel_ff] <= drive_try_ff;
                  end
               end else begin
                  drive_ff[sel_ff] <= drive_try_ff;
               end
               sel_ff       <= sel_in;
               pend_cell_ff <= 3'(sel_in);
               state_ff     <= S_EMIT;
            end
            S_TCK_MUL: begin
               state_ff <= S_TCK_ACC;
            end
            S_TCK_ACC: begin
               energy_ff[tick_idx_ff]   <= energy_ff[tick_idx_ff]
                                           + {{(64-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
               capacity_ff[tick_idx_ff] <= capacity_ff[tick_idx_ff]
                                           + {24'd0, tick_drive_abs};
               pend_kind_ff   <= KIND_DUTY;
               pend_cell_ff   <= 3'(tick_idx_ff);
               pend_duty_ff   <= {{8{tick_drive[7]}}, tick_drive} + {1'b0, pwm_fs_ff[15:1]};
               pend_prog_ff   <= running_ff[tick_idx_ff];
               pend_energy_ff <= '0;
               pend_cap_ff    <= '0;
               pend_last_ff   <= (tick_idx_ff == LAST_CELL);
               state_ff       <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_kind_ff   <= pend_kind_ff;
                  rsp_cell_ff   <= pend_cell_ff;
                  rsp_duty_ff   <= pend_duty_ff;
                  rsp_prog_ff   <= pend_prog_ff;
                  rsp_energy_ff <= pend_energy_ff;
                  rsp_cap_ff    <= pend_cap_ff;
                  rsp_last_ff   <= pend_last_ff;
                  if (pend_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     tick_idx_ff <= tick_idx_ff + CIW'(1);
                     state_ff    <= S_TCK_MUL;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_cell_res    = rsp_cell_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_in_progress = rsp_prog_ff;
   assign rsp_energy      = rsp_energy_ff;
   assign rsp_capacity    = rsp_cap_ff;
   assign rsp_last        = rsp_last_ff;

   // The sample pointer and the tick walk never leave the cell range.
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      sel_ff <= LAST_CELL)
      else $error("sample pointer beyond last cell");

   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_idx_ff <= LAST_CELL)
      else $error("tick index beyond last cell");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_type == REQ_TICK |=> state_ff == S_TCK_MUL && tick_idx_ff == '0)
      else $error("tick did not start at the first cell");

   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && out_free |=> rsp_valid_ff)
      else $error("pending result not moved to the output register");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && out_free && pend_last_ff |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle after the final result");

endmodule

`default_nettype wire

@@ sim/battery_cc_cv_test_controller_test.sv @@
// Self-checking testbench for the battery CC/CV test controller: predictor, scoreboard, drivers.
`timescale 1ns / 100ps

module battery_cc_cv_test_controller_test;
   import bcc_pkg::*;

   typedef struct {
      logic [1:0]         rtype;
      logic [2:0]         cell_no;
      logic signed [15:0] sample;
      logic [1:0]         control;
      logic signed [15:0] bound;
      logic [6:0]         max_cur;
      logic [7:0]         ratio;
   } bcc_request_type;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  cell_no;
      logic [15:0] duty;
      logic        prog;
      logic [63:0] energy;
      logic [31:0] capacity;
      logic        last;
   } bcc_result_type;

   class cc_cv_scoreboard #(int NC = 2);
      localparam int MAX_PRINTED = 40;

      int unsigned gain;
      int unsigned full_scale;
      int          selected;
      int          target_v[NC];
      int          limit[NC];
      int          ratio[NC];
      bit          running[NC];
      int          timer[NC];
      int          drive[NC];
      int          volts[NC];
      logic [63:0] energy_acc[NC];
      logic [31:0] capacity_acc[NC];

      bcc_result_type pending_results[$];
      int          errors;
      int          checked;
      int          clamps;
      int          cutoffs;

      function new();
         gain = 32'(GAIN_RESET);
         full_scale = 32'(PWM_FS_RESET);
         selected = 0;
         for (int i = 0; i < NC; i++) begin
            target_v[i] = 0;
            limit[i] = 0;
            ratio[i] = 0;
            running[i] = 0;
            timer[i] = 0;
            drive[i] = 0;
            volts[i] = 0;
            energy_acc[i] = '0;
            capacity_acc[i] = '0;
         end
         errors = 0;
         checked = 0;
         clamps = 0;
         cutoffs = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
         if (idx == CSR_FEEDBACK_GAIN) begin
            gain = 32'(value[7:0]);
         end else begin
            full_scale = 32'(value);
         end
      endfunction

      function void push_result(logic [1:0] kind, int cell_no, logic [15:0] duty, bit prog,
                                logic [63:0] en, logic [31:0] cap, bit last);
         bcc_result_type r;
         r.kind = kind;
         r.cell_no = 3'(cell_no);
         r.duty = duty;
         r.prog = prog;
         r.energy = en;
         r.capacity = cap;
         r.last = last;
         pending_results.push_back(r);
      endfunction

      // Works out the result beats of one accepted request and advances the cell state.
      function void note_request(bcc_request_type q);
         int          c;
         int          v;
         logic [31:0] prod;
         int          cv;
         int          mag;
         int          pwm;
         int          r;
         logic [15:0] duty16;
         case (q.rtype)
            REQ_SAMPLE: begin
               c = selected % NC;
               v = int'(q.sample);
               volts[c] = v;
               pwm = 0;
               if (running[c]) begin
                  prod = $unsigned(target_v[c] - v) * gain;
                  cv = int'($signed(prod[15:0]));
                  mag = cv < 0 ? -cv : cv;
                  if (mag > limit[c]) begin
                     pwm = cv > 0 ? limit[c] : -limit[c];
                     timer[c] = 0;
                     clamps++;
                  end else begin
                     pwm = cv;
                     r = ratio[c] * pwm;
                     if (r < 0) r = -r;
                     if (r < limit[c]) begin
                        if (timer[c] >= int'(TIMER_LIMIT)) begin
                           running[c] = 0;
                           timer[c] = 0;
                           pwm = 0;
                           cutoffs++;
                        end else begin
                           timer[c]++;
                        end
                     end
                  end
               end
               drive[c] = pwm;
               selected = (c + 1) % NC;
               push_result(KIND_SAMPLE, selected, '0, 1'b0, '0, '0, 1'b1);
            end
            REQ_TICK: begin
               for (int i = 0; i < NC; i++) begin
                  energy_acc[i] = energy_acc[i] + 64'(longint'(volts[i] * drive[i]));
                  capacity_acc[i] = capacity_acc[i] + 32'(drive[i] < 0 ? -drive[i] : drive[i]);
               end
               for (int i = 0; i < NC; i++) begin
                  duty16 = 16'(drive[i] + int'(full_scale / 2));
                  push_result(KIND_DUTY, i, duty16, running[i], '0, '0, i == NC - 1);
               end
            end
            REQ_COMMAND: begin
               if (q.cell_no >= NC) begin
                  push_result(KIND_REPORT, int'(q.cell_no), '0, 1'b0, '0, '0, 1'b1);
               end else begin
                  if (q.control == CTL_STOP) begin
                     running[q.cell_no] = 0;
                  end else if (q.control == CTL_START) begin
                     running[q.cell_no] = 1;
                  end
                  push_result(KIND_REPORT, int'(q.cell_no), '0, running[q.cell_no],
                              energy_acc[q.cell_no], capacity_acc[q.cell_no], 1'b1);
                  energy_acc[q.cell_no] = '0;
                  capacity_acc[q.cell_no] = '0;
               end
            end
            default: begin
               if (q.cell_no < NC) begin
                  target_v[q.cell_no] = int'(q.bound);
                  limit[q.cell_no] = int'(q.max_cur);
                  ratio[q.cell_no] = int'(q.ratio);
               end
            end
         endcase
      endfunction

      task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d (%s): got 0x%0h, want 0x%0h",
                     checked, what, got_v, want_v);
      endtask

      task check_response(logic [1:0] kind, logic [2:0] cell_no, logic [15:0] duty,
                          logic prog, logic [63:0] en, logic [31:0] cap, logic last);
         bcc_result_type w;
         checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", 64'(kind), '0);
            return;
         end
         w = pending_results.pop_front();
         if (kind !== w.kind) report_mismatch("kind", 64'(kind), 64'(w.kind));
         if (cell_no !== w.cell_no) report_mismatch("cell", 64'(cell_no), 64'(w.cell_no));
         if (duty !== w.duty) report_mismatch("duty", 64'(duty), 64'(w.duty));
         if (prog !== w.prog) report_mismatch("in_progress", 64'(prog), 64'(w.prog));
         if (en !== w.energy) report_mismatch("energy", en, w.energy);
         if (cap !== w.capacity) report_mismatch("capacity", 64'(cap), 64'(w.capacity));
         if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
      endtask
   endclass

   localparam int CELLS = CELLS_DEFAULT;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_TAIL = 3 * CELLS + 1 + 16;
   localparam logic [1:0] CTL_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTY} stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = '0;
   logic [2:0]            req_cell_req = '0;
   logic signed [15:0]    req_sample = '0;
   logic [1:0]            req_control = '0;
   logic signed [15:0]    req_bound_voltage = '0;
   logic [6:0]            req_max_current = '0;
   logic [7:0]            req_cutoff_ratio = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [2:0]            rsp_cell_res;
   logic [15:0]           rsp_duty;
   logic                  rsp_in_progress;
   logic signed [63:0]    rsp_energy;
   logic [31:0]           rsp_capacity;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cc_cv_scoreboard #(CELLS) sb;
   int                       sent = 0;
   int                       cycle_count = 0;
   stall_mode_type           stall_mode = STALL_NONE;
   int                       stall_tick = 0;
   int                       stall_burst = 0;

   battery_cc_cv_test_controller #(.CELLS(CELLS)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_cell_req      (req_cell_req),
      .req_sample        (req_sample),
      .req_control       (req_control),
      .req_bound_voltage (req_bound_voltage),
      .req_max_current   (req_max_current),
      .req_cutoff_ratio  (req_cutoff_ratio),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_cell_res      (rsp_cell_res),
      .rsp_duty          (rsp_duty),
      .rsp_in_progress   (rsp_in_progress),
      .rsp_energy        (rsp_energy),
      .rsp_capacity      (rsp_capacity),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver drives rsp_stall in a randomly chosen stall style that is re-picked periodically.
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 97 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: rsp_stall = 1'b0;
         STALL_RANDOM: rsp_stall = $urandom_range(0, 99) < 30;
         STALL_PERIODIC: rsp_stall = (stall_tick % 7) < 3;
         default: begin
            if (stall_burst > 0) begin
               stall_burst--;
               rsp_stall = 1'b1;
            end else begin
               rsp_stall = 1'b0;
               if ($urandom_range(0, 99) < 6) stall_burst = int'($urandom_range(4, 16));
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_kind, rsp_cell_res, rsp_duty, rsp_in_progress, rsp_energy,
                           rsp_capacity, rsp_last);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending",
                  cycle_count, sb.pending_results.size());
         $display("[battery_cc_cv_test_controller] ERROR");
         $finish;
      end
   end

   function automatic bcc_request_type make_request(logic [1:0] t, int cell_no, int sample,
                                                    logic [1:0] ctl, int bound, int maxc,
                                                    int rat);
      bcc_request_type q;
      q.rtype = t;
      q.cell_no = 3'(cell_no);
      q.sample = 16'(sample);
      q.control = ctl;
      q.bound = 16'(bound);
      q.max_cur = 7'(maxc);
      q.ratio = 8'(rat);
      return q;
   endfunction

   // Tame requests keep running cells near their target so the cutoff timer can expire;
   // wild requests cover the whole field space.
   function automatic bcc_request_type pick_request(bit tame);
      bcc_request_type q;
      int           roll;
      int           c;
      int           span;
      int           v;
      q.rtype = 2'($urandom);
      q.cell_no = 3'($urandom);
      q.sample = 16'($urandom);
      q.control = 2'($urandom);
      q.bound = 16'($urandom);
      q.max_cur = 7'($urandom);
      q.ratio = 8'($urandom);
      roll = int'($urandom_range(0, 99));
      if (tame) begin
         q.cell_no = 3'($urandom_range(0, CELLS - 1));
         if (roll < 88) begin
            q.rtype = REQ_SAMPLE;
            c = sb.selected % CELLS;
            span = (sb.gain == 0) ? 0 : sb.limit[c] / int'(sb.gain);
            v = sb.target_v[c] - (int'($urandom_range(0, 2 * span)) - span);
            if (v > 32767) v = 32767;
            else if (v < -32768) v = -32768;
            q.sample = 16'(v);
         end else if (roll < 94) begin
            q.rtype = REQ_TICK;
         end else if (roll < 98) begin
            q.rtype = REQ_COMMAND;
            roll = int'($urandom_range(0, 19));
            q.control = roll == 0 ? CTL_STOP : roll < 3 ? CTL_START :
                        roll < 11 ? CTL_KEEP : CTL_UNUSED;
         end else begin
            q.rtype = REQ_SET;
            q.bound = 16'(int'($urandom_range(0, 60000)) - 30000);
            q.max_cur = 7'($urandom_range(8, 127));
            q.ratio = 8'($urandom_range(0, 1));
         end
      end else begin
         q.rtype = roll < 45 ? REQ_SAMPLE : roll < 65 ? REQ_TICK :
                   roll < 85 ? REQ_COMMAND : REQ_SET;
         if ($urandom_range(0, 9) < 7) q.cell_no = 3'($urandom_range(0, CELLS - 1));
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: q.sample = 16'sh8000;
               1: q.sample = 16'sh7FFF;
               2: q.sample = 16'sh0000;
               default: q.sample = 16'shFFFF;
            endcase
         end
         if ($urandom_range(0, 4) == 0) q.bound = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
         if ($urandom_range(0, 4) == 0) q.max_cur = $urandom_range(0, 1) ? 7'd127 : 7'd0;
         if ($urandom_range(0, 4) == 0) q.ratio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      return q;
   endfunction

   task automatic send_request(input bcc_request_type q);
      @(negedge clock);
      req_type = q.rtype;
      req_cell_req = q.cell_no;
      req_sample = q.sample;
      req_control = q.control;
      req_bound_voltage = q.bound;
      req_max_current = q.max_cur;
      req_cutoff_ratio = q.ratio;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(q);
      sent++;
   endtask

   // Idle cycles on the request side carry junk on the payload.
   task automatic idle_request(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_type = 2'($urandom);
         req_cell_req = 3'($urandom);
         req_sample = 16'($urandom);
         req_control = 2'($urandom);
         req_bound_voltage = 16'($urandom);
         req_max_current = 7'($urandom);
         req_cutoff_ratio = 8'($urandom);
      end
   endtask

   task automatic wait_drained();
      idle_request(1);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      sb.write_register(idx, value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      csr_index = CSR_IDX_W'($urandom);
      csr_wdata = CSR_DATA_W'($urandom);
   endtask

   task automatic run_phase(input int count, input bit tame);
      int           done;
      int           burst;
      bcc_request_type q;
      done = 0;
      burst = int'($urandom_range(1, 24));
      if (tame) begin
         for (int c = 0; c < CELLS; c++) begin
            send_request(make_request(REQ_SET, c, 0, CTL_KEEP,
                                      int'($urandom_range(0, 60000)) - 30000,
                                      int'($urandom_range(8, 127)),
                                      int'($urandom_range(0, 1))));
            send_request(make_request(REQ_COMMAND, c, 0, CTL_START, 0, 0, 0));
         end
      end
      while (done < count) begin
         q = pick_request(tame);
         send_request(q);
         if (!(q.rtype == REQ_SET && q.cell_no >= CELLS)) done++;
         burst = burst - 1;
         if ($urandom_range(0, 199) == 0) begin
            wait_drained();
         end else if (burst == 0) begin
            burst = int'($urandom_range(1, 24));
            idle_request($urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 6)));
         end
      end
      wait_drained();
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats at the reset register values.
      send_request(make_request(REQ_SAMPLE, 0, 32767, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 5, -32768, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_TICK, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 0, 0, CTL_UNUSED, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 7, 0, CTL_START, 0, 0, 0));
      send_request(make_request(REQ_SET, 5, 0, CTL_KEEP, 32767, 127, 255));
      send_request(make_request(REQ_SET, 0, 0, CTL_KEEP, 32767, 127, 255));
      send_request(make_request(REQ_SET, 1, 0, CTL_KEEP, -32768, 127, 0));
      send_request(make_request(REQ_COMMAND, 0, 0, CTL_START, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 1, 0, CTL_START, 0, 0, 0));
      // Positive clamp, then an error of -32768 that must also clamp.
      send_request(make_request(REQ_SAMPLE, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_TICK, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, 32000, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, -32700, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_TICK, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 1, 0, CTL_STOP, 0, 0, 0));
      // An error of +32768 wraps to a negative drive and clamps low.
      send_request(make_request(REQ_SAMPLE, 0, -1, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, 12345, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SET, 0, 0, CTL_KEEP, 100, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, 100, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_SAMPLE, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_TICK, 0, 0, CTL_KEEP, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 0, 0, CTL_STOP, 0, 0, 0));
      send_request(make_request(REQ_COMMAND, 1, 0, CTL_KEEP, 0, 0, 0));
      wait_drained();

      write_csr(CSR_FEEDBACK_GAIN, {8'($urandom), 8'd1});
      write_csr(CSR_PWM_FULL_SCALE, 16'd255);
      run_phase(600, 1'b1);

      write_csr(CSR_FEEDBACK_GAIN, 16'd255);
      write_csr(CSR_PWM_FULL_SCALE, 16'hFFFF);
      run_phase(200, 1'b0);

      write_csr(CSR_FEEDBACK_GAIN, 16'd0);
      write_csr(CSR_PWM_FULL_SCALE, 16'd1);
      run_phase(100, 1'b0);

      write_csr(CSR_FEEDBACK_GAIN, {8'($urandom), 8'($urandom_range(1, 4))});
      write_csr(CSR_PWM_FULL_SCALE, 16'($urandom_range(1, 65535)));
      run_phase(200, 1'b1);

      write_csr(CSR_FEEDBACK_GAIN, 16'($urandom));
      write_csr(CSR_PWM_FULL_SCALE, 16'($urandom_range(1, 65535)));
      run_phase(60, 1'b0);

      if (sb.pending_results.size() != 0)
         sb.report_mismatch("beats never delivered", 64'(sb.pending_results.size()), '0);

      $display("Summary: %0d requests sent, %0d result beats checked,",
               sent, sb.checked);
      $display("Summary: %0d clamped samples and %0d cutoff stops predicted, %0d mismatches.",
               sb.clamps, sb.cutoffs, sb.errors);
      if (sb.errors == 0) begin
         $display("[battery_cc_cv_test_controller] OK");
      end else begin
         $display("[battery_cc_cv_test_controller] ERROR");
      end
      $finish;
   end
endmodule
